// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion helpers for the pixel blend block
// wraps concurrent assertions so they can be compiled out as a group
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define ABP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("abp assertion failed");
// checked at every edge, reset included
`define ABP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("abp assertion failed");
`else
`define ABP_ASSERT(lbl, clk, rst_n, prop)
`define ABP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hdl/abp_pkg.sv -----
// ---------------------------------------------------------------------------
// abp_pkg
// shared types, codes and arithmetic helpers of the pixel blend block
// ---------------------------------------------------------------------------
`default_nettype none

package abp_pkg;

  // framebuffer layouts
  localparam logic [1:0] FMT_RGB565   = 2'd0;
  localparam logic [1:0] FMT_RGB888   = 2'd1;
  localparam logic [1:0] FMT_ARGB8888 = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_RGBA   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 1'd1;

  // reset values
  localparam logic [31:0] COLOR_RESET  = 32'h0000_0000;
  localparam logic [1:0]  FORMAT_RESET = FMT_ARGB8888;

  // classified pixel, held in the queue between front and back
  typedef struct packed {
    logic [1:0] fmt;
    logic       zero_alpha;
    logic [7:0] alpha;
    logic [7:0] sr;
    logic [7:0] sg;
    logic [7:0] sb;
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
  } abp_entry_t;

  // s*a + d*(255-a) + 127, at most 65152
  function automatic logic [15:0] blend_sum(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] a);
    logic [15:0] ps;
    logic [15:0] pd;
    logic [7:0]  ia;
    ia = 8'hff - a;
    ps = {8'd0, s} * {8'd0, a};
    pd = {8'd0, d} * {8'd0, ia};
    return ps + pd + 16'd127;
  endfunction

  // exact x/255 for x up to 65152 (any blend_sum result), by shift and add
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/abp_front.sv -----
// ---------------------------------------------------------------------------
// abp_front
// configuration registers, pixel acceptance and channel unpacking
// ---------------------------------------------------------------------------
`default_nettype none

module abp_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [abp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [31:0]                   dest_pixel_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output abp_pkg::abp_entry_t                entry_o
);
  import abp_pkg::*;

  logic [31:0] color_q;
  logic [1:0]  format_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q  <= COLOR_RESET;
      format_q <= FORMAT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOR_RGBA:   color_q  <= cfg_wdata_i;
        CFG_PIXEL_FORMAT: format_q <= cfg_wdata_i[1:0];
        default:          ;
      endcase
    end
  end

  // accept while the queue has room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify the transaction: source colour and unpacked destination channels
  always_comb begin
    entry_o.fmt        = format_q;
    entry_o.alpha      = color_q[7:0];
    entry_o.zero_alpha = (color_q[7:0] == 8'd0);
    entry_o.sr         = color_q[31:24];
    entry_o.sg         = color_q[23:16];
    entry_o.sb         = color_q[15:8];
    if (format_q == FMT_RGB565) begin
      entry_o.dr = {dest_pixel_i[15:11], 3'b000};
      entry_o.dg = {dest_pixel_i[10:5], 2'b00};
      entry_o.db = {dest_pixel_i[4:0], 3'b000};
    end else begin
      entry_o.dr = dest_pixel_i[23:16];
      entry_o.dg = dest_pixel_i[15:8];
      entry_o.db = dest_pixel_i[7:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/abp_queue.sv -----
// ---------------------------------------------------------------------------
// abp_queue
// short first-in first-out queue decoupling the front from the back
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module abp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  abp_pkg::abp_entry_t      push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output abp_pkg::abp_entry_t      pop_data_o
);
  import abp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  abp_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == FULL_CNT);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ABP_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FULL_CNT)
  `ABP_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop_i |-> count_q != '0)
  `ABP_ASSERT(a_push_grows, clk_i, rst_ni,
    (push_i && !pop_i) |=> (count_q == CNT_W'($past(count_q) + 1'b1)))

endmodule

`default_nettype wire

// ----- hdl/abp_back.sv -----
// ---------------------------------------------------------------------------
// abp_back
// blend pipeline: channel products, divide by 255, repack, output register
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module abp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  abp_pkg::abp_entry_t q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [31:0]        new_pixel_o,
  output logic               write_enable_o
);
  import abp_pkg::*;

  // stage one: weighted sums
  logic        s1_valid_q;
  logic [1:0]  s1_fmt_q;
  logic        s1_zero_q;
  logic [7:0]  s1_alpha_q;
  logic [15:0] s1_r_q, s1_g_q, s1_b_q;

  // output register
  logic        out_valid_q;
  logic [31:0] pixel_q, pixel_d;
  logic        we_q;

  logic [7:0]  r, g, b;
  logic        out_ready;
  logic        s1_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign pop_o     = q_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_fmt_q   <= q_data_i.fmt;
      s1_zero_q  <= q_data_i.zero_alpha;
      s1_alpha_q <= q_data_i.alpha;
      s1_r_q     <= blend_sum(q_data_i.sr, q_data_i.dr, q_data_i.alpha);
      s1_g_q     <= blend_sum(q_data_i.sg, q_data_i.dg, q_data_i.alpha);
      s1_b_q     <= blend_sum(q_data_i.sb, q_data_i.db, q_data_i.alpha);
    end
  end

  // divide by 255 and repack into the framebuffer layout
  assign r = div255(s1_r_q);
  assign g = div255(s1_g_q);
  assign b = div255(s1_b_q);

  always_comb begin
    unique case (s1_fmt_q)
      FMT_RGB565: pixel_d = {16'd0, r[7:3], g[7:2], b[7:3]};
      FMT_RGB888: pixel_d = {8'd0, r, g, b};
      default:    pixel_d = {s1_alpha_q, r, g, b};
    endcase
    if (s1_zero_q) begin
      pixel_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      pixel_q <= pixel_d;
      we_q    <= !s1_zero_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_pixel_o    = pixel_q;
  assign write_enable_o = we_q;

  `ABP_ASSERT(a_skip_is_zero, clk_i, rst_ni,
    (out_valid_q && !we_q) |-> (pixel_q == 32'd0))
  `ABP_ASSERT(a_pop_advances, clk_i, rst_ni, pop_o |-> (!s1_valid_q || out_ready))
  `ABP_ASSERT(a_out_from_s1, clk_i, rst_ni, $rose(out_valid_q) |-> $past(s1_valid_q))

endmodule

`default_nettype wire

// ----- hdl/alpha_blend_pixel_top.sv -----
// path: an accepted pixel passes through the queue, the stage-one sums register and the output register
// throughput: one pixel per cycle while out_stall_i is low, sustained through the two-stage blend pipeline
// the queue between acceptance and blend lets input and output stall independently
// reset: control cleared, colour register 0, pixel format ARGB8888, no results pending
// ---------------------------------------------------------------------------
// alpha_blend_pixel_top
// source-over blend of a constant RGBA colour onto streamed framebuffer pixels
// ---------------------------------------------------------------------------
`default_nettype none

module alpha_blend_pixel_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [abp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [31:0]                   dest_pixel_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [31:0]                        new_pixel_o,
  output logic                               write_enable_o
);
  import abp_pkg::*;

  abp_entry_t push_data;
  abp_entry_t pop_data;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;

  // front: configuration and classification
  abp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .dest_pixel_i (dest_pixel_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_data)
  );

  // decoupling queue
  abp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  // back: blend pipeline and output register
  abp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (pop_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_pixel_o    (new_pixel_o),
    .write_enable_o (write_enable_o)
  );

endmodule

`default_nettype wire
